// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, cond, prop)
`define ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

// ===== design/plp_pkg.sv =====
// ----------------------------------------------------------------------------
// plp_pkg
// Shared widths, codes and types of the positional list table.
// ----------------------------------------------------------------------------
`default_nettype none

package plp_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int OP_W      = 2;
  localparam int POS_W     = 7;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 3;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int MAX_RES   = 64;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_INSERT   = 2'd0;
  localparam op_t OP_DELETE   = 2'd1;
  localparam op_t OP_SEARCH   = 2'd2;
  localparam op_t OP_TRAVERSE = 2'd3;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BADPOS   = 3'd1;
  localparam status_t ST_NOTFOUND = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_EMPTY    = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_PUSH,
    S_TRAV
  } plp_state_t;

  // Per-cycle commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic rot;
    logic srch;
  } plp_cmd_t;

  // One result item
  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   data_out;
    logic        [IDX_W-1:0]   index;
    logic        [CNT_W-1:0]   count;
    logic                      last;
  } plp_res_t;

endpackage

`default_nettype wire

// ===== design/plp_if.sv =====
// ----------------------------------------------------------------------------
// plp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface plp_in_if import plp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, operation, position, value, input ready);
  modport sink   (input valid, operation, position, value, output ready);
endinterface

interface plp_out_if import plp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] data_out;
  logic [IDX_W-1:0]        index;
  logic [CNT_W-1:0]        count;
  logic                    last;

  modport source (output valid, status, data_out, index, count, last, input ready);
  modport sink   (input valid, status, data_out, index, count, last, output ready);
endinterface

`default_nettype wire

// ===== design/positional_list_table.sv =====
// ----------------------------------------------------------------------------
// positional_list_table
// Ordered list of signed words with insert, delete, search and traverse.
// ----------------------------------------------------------------------------
// Usage: request items arrive on in_ch (operation, 1-based position, value);
// result items leave on out_ch (status, data_out, index, count, last).
// A row of DEPTH cells holds the list; insert and delete shift the cells
// from the position on at once. A search or delete captures the row into
// a registered priority tree of log2(DEPTH) levels picking the lowest match.
// Path from acceptance to result in the output register:
//   insert, bad position, full, empty traverse: through S_PUSH
//   search, valid delete: through S_WAIT for the tree, then S_PUSH
//   traverse: one result per cycle, while out_ch does not stall, as the row
//   rotates one slot per cycle; at most 64 results.
// A new item is taken once the previous one has left for the output
// register, even while that result still waits there.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result. When out_ch stalls, the output register holds its item; a
// traverse freezes its rotation until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module positional_list_table
  import plp_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  plp_in_if.sink         in_ch,
  plp_out_if.source      out_ch
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int LV = $clog2(DEPTH);
  localparam int WW = $clog2(LV+1);
  localparam int MW = (CW + 1 > CNT_W) ? CW + 1 : CNT_W;

  plp_state_t state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic [WW-1:0]  wait_r, wait_nxt;
  logic           is_del_r, is_del_nxt;
  plp_res_t       pend_r, pend_nxt;
  plp_res_t       out_r, out_nxt;
  logic           out_valid_r;

  plp_cmd_t       cmd_c;
  logic           launch_c;
  logic           load_out_c;

  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic                    match_a   [DEPTH];
  logic                    root_hit;
  logic [LV-1:0]           root_idx;
  logic signed [VAL_W-1:0] root_data;

  // Request decode
  logic          acc_c;
  logic [MW-1:0] pos_e, cnt_e, k_e, lim_e;
  logic [CW-1:0] p_c, last_idx_c;
  logic          ins_bad_c, full_c, del_bad_c, ins_ok_c, del_ok_c;
  logic          slot_free_c, wait_done_c, emit_c, adv_c;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc_c       = in_ch.valid && in_ch.ready;

  assign pos_e      = MW'(in_ch.position);
  assign cnt_e      = MW'(cnt_r);
  assign p_c        = CW'(pos_e - MW'(1));
  assign last_idx_c = cnt_r - CW'(1);
  assign ins_bad_c  = (pos_e == '0) || (pos_e > cnt_e + MW'(1));
  assign full_c     = (cnt_r == CW'(DEPTH));
  assign del_bad_c  = (pos_e == '0) || (pos_e > cnt_e);
  assign ins_ok_c   = (in_ch.operation == OP_INSERT) && !ins_bad_c && !full_c;
  assign del_ok_c   = (in_ch.operation == OP_DELETE) && !del_bad_c;

  assign slot_free_c = !out_valid_r || out_ch.ready;
  assign wait_done_c = (wait_r == WW'(LV));

  // Traverse emits while the step count is below min(count, MAX_RES)
  assign k_e    = MW'(k_r);
  assign lim_e  = (cnt_e > MW'(MAX_RES)) ? MW'(MAX_RES) : cnt_e;
  assign emit_c = (k_e < lim_e);
  assign adv_c  = !emit_c || slot_free_c;

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = in_ch.value;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end

    plp_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd_c),
      .value      (in_ch.value),
      .p          (p_c),
      .cnt        (cnt_r),
      .last_idx   (last_idx_c),
      .left_data  (left_d),
      .right_data (right_d),
      .first_data (cell_data[0]),
      .data       (cell_data[i]),
      .match      (match_a[i])
    );
  end

  plp_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk       (clk),
    .launch    (launch_c),
    .match     (match_a),
    .cell_data (cell_data),
    .root_hit  (root_hit),
    .root_idx  (root_idx),
    .root_data (root_data)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc_c) begin
          case (in_ch.operation)
            OP_INSERT:   state_nxt = S_PUSH;
            OP_DELETE:   state_nxt = del_bad_c ? S_PUSH : S_WAIT;
            OP_SEARCH:   state_nxt = S_WAIT;
            OP_TRAVERSE: state_nxt = (cnt_r == '0) ? S_PUSH : S_TRAV;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_WAIT: begin
        if (wait_done_c) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (slot_free_c) begin
          state_nxt = S_IDLE;
        end
      end
      S_TRAV: begin
        if (adv_c && (k_r == last_idx_c)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control and result build
  always_comb begin
    cmd_c      = '0;
    launch_c   = 1'b0;
    load_out_c = 1'b0;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    wait_nxt   = wait_r;
    is_del_nxt = is_del_r;
    pend_nxt   = pend_r;
    out_nxt    = out_r;
    case (state_r)
      S_IDLE: begin
        cmd_c.srch = (in_ch.operation == OP_SEARCH);
        if (acc_c) begin
          pend_nxt = '{status: ST_OK, data_out: '0, index: '0,
                       count: CNT_W'(cnt_r), last: 1'b1};
          wait_nxt = '0;
          k_nxt    = '0;
          case (in_ch.operation)
            OP_INSERT: begin
              if (ins_bad_c) begin
                pend_nxt.status = ST_BADPOS;
              end else if (full_c) begin
                pend_nxt.status = ST_FULL;
              end else begin
                cmd_c.ins      = 1'b1;
                cnt_nxt        = cnt_r + CW'(1);
                pend_nxt.count = CNT_W'(cnt_r + CW'(1));
              end
            end
            OP_DELETE: begin
              if (del_bad_c) begin
                pend_nxt.status = ST_BADPOS;
              end else begin
                cmd_c.del  = 1'b1;
                launch_c   = 1'b1;
                is_del_nxt = 1'b1;
                cnt_nxt    = cnt_r - CW'(1);
              end
            end
            OP_SEARCH: begin
              launch_c   = 1'b1;
              is_del_nxt = 1'b0;
            end
            OP_TRAVERSE: begin
              pend_nxt.status = ST_EMPTY;
            end
            default: pend_nxt = pend_r;
          endcase
        end
      end
      S_WAIT: begin
        wait_nxt = wait_r + WW'(1);
        if (wait_done_c) begin
          pend_nxt.count = CNT_W'(cnt_r);
          if (is_del_r) begin
            pend_nxt.status   = ST_OK;
            pend_nxt.data_out = root_data;
            pend_nxt.index    = IDX_W'(root_idx);
          end else if (root_hit) begin
            pend_nxt.status   = ST_OK;
            pend_nxt.data_out = '0;
            pend_nxt.index    = IDX_W'(root_idx);
          end else begin
            pend_nxt.status   = ST_NOTFOUND;
            pend_nxt.data_out = '0;
            pend_nxt.index    = '0;
          end
        end
      end
      S_PUSH: begin
        if (slot_free_c) begin
          load_out_c = 1'b1;
          out_nxt    = pend_r;
        end
      end
      S_TRAV: begin
        if (emit_c && slot_free_c) begin
          load_out_c = 1'b1;
          out_nxt    = '{status: ST_OK, data_out: cell_data[0], index: IDX_W'(k_r),
                         count: CNT_W'(cnt_r), last: (k_e + MW'(1) == lim_e)};
        end
        if (adv_c) begin
          cmd_c.rot = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
      end
      default: begin
        cmd_c = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      k_r         <= '0;
      wait_r      <= '0;
      is_del_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      wait_r   <= wait_nxt;
      is_del_r <= is_del_nxt;
      if (load_out_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.data_out = out_r.data_out;
  assign out_ch.index    = out_r.index;
  assign out_ch.count    = out_r.count;
  assign out_ch.last     = out_r.last;

  // Checks
  `ASSERT_IMPL(a_cnt_cap, 1'b1, cnt_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_ins_grow, acc_c && ins_ok_c, cnt_r == $past(cnt_r) + CW'(1))
  `ASSERT_NEXT(a_del_shrink, acc_c && del_ok_c, cnt_r == $past(cnt_r) - CW'(1))
  `ASSERT_IMPL(a_wait_bound, state_r == S_WAIT, wait_r <= WW'(LV))

endmodule

`default_nettype wire

// ===== design/plp_cell.sv =====
// ----------------------------------------------------------------------------
// plp_cell
// One list slot: holds an entry, shifts with its neighbors, flags a match.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_cell
  import plp_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int CELL_IDX = 0
) (
  input  wire logic                           clk,
  input  wire plp_cmd_t                       cmd,
  input  wire logic signed [VAL_W-1:0]        value,
  input  wire logic [$clog2(DEPTH+1)-1:0]     p,
  input  wire logic [$clog2(DEPTH+1)-1:0]     cnt,
  input  wire logic [$clog2(DEPTH+1)-1:0]     last_idx,
  input  wire logic signed [VAL_W-1:0]        left_data,
  input  wire logic signed [VAL_W-1:0]        right_data,
  input  wire logic signed [VAL_W-1:0]        first_data,
  output logic signed [VAL_W-1:0]             data,
  output logic                                match
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] IDX = CW'(CELL_IDX);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  // Pick the next entry: open a gap, close a gap or rotate the live span
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (IDX > p) begin
        data_nxt = left_data;
      end else if (IDX == p) begin
        data_nxt = value;
      end
    end else if (cmd.del) begin
      if (IDX >= p) begin
        data_nxt = right_data;
      end
    end else if (cmd.rot) begin
      if (IDX == last_idx) begin
        data_nxt = first_data;
      end else if (IDX < last_idx) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Flag a live entry equal to the key, or the slot addressed for removal
  always_comb begin
    if (cmd.srch) begin
      match = (data_r == value) && (IDX < cnt);
    end else begin
      match = (IDX == p);
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== design/plp_tree.sv =====
// ----------------------------------------------------------------------------
// plp_tree
// Registered priority tree: lowest flagged slot with its index and entry.
// ----------------------------------------------------------------------------
`default_nettype none

module plp_tree
  import plp_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          launch,
  input  wire logic                          match [DEPTH],
  input  wire logic signed [VAL_W-1:0]       cell_data [DEPTH],
  output logic                               root_hit,
  output logic [$clog2(DEPTH)-1:0]           root_idx,
  output logic signed [VAL_W-1:0]            root_data
);

  localparam int LV = $clog2(DEPTH);
  localparam int NP = 1 << LV;

  // Heap layout: node n has children 2n and 2n+1, leaves at NP .. 2NP-1
  logic                    hit_r [1:2*NP-1];
  logic [LV-1:0]           idx_r [1:2*NP-1];
  logic signed [VAL_W-1:0] dat_r [1:2*NP-1];

  // Capture the leaves on launch, hold them otherwise
  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < DEPTH) begin : g_live
      always_ff @(posedge clk) begin
        if (launch) begin
          hit_r[NP+i] <= match[i];
          idx_r[NP+i] <= LV'(i);
          dat_r[NP+i] <= cell_data[i];
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (launch) begin
          hit_r[NP+i] <= 1'b0;
          idx_r[NP+i] <= LV'(i);
          dat_r[NP+i] <= '0;
        end
      end
    end
  end

  // Reduce one level per cycle, lower index wins
  for (genvar n = 1; n < NP; n++) begin : g_node
    always_ff @(posedge clk) begin
      hit_r[n] <= hit_r[2*n] | hit_r[2*n+1];
      if (hit_r[2*n]) begin
        idx_r[n] <= idx_r[2*n];
        dat_r[n] <= dat_r[2*n];
      end else begin
        idx_r[n] <= idx_r[2*n+1];
        dat_r[n] <= dat_r[2*n+1];
      end
    end
  end

  assign root_hit  = hit_r[1];
  assign root_idx  = idx_r[1];
  assign root_data = dat_r[1];

endmodule

`default_nettype wire
